[rtl/core/id3_pkg.sv]
package id3_pkg;

  localparam int LEN_W   = 28;
  localparam int RES_MAX = 5;
  localparam int CNT_W   = $clog2(RES_MAX + 1);

  localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(10);
  localparam logic [LEN_W-1:0] LANG_BODY = LEN_W'(4);
  localparam logic [6:0]       SYNC_MASK = 7'h7F;

  localparam logic [7:0] BYTE_I    = 8'h49;
  localparam logic [7:0] BYTE_D    = 8'h44;
  localparam logic [7:0] BYTE_3    = 8'h33;
  localparam logic [7:0] VER_MAJOR = 8'h04;
  localparam logic [7:0] VER_MINOR = 8'h00;
  localparam logic [7:0] ENC_LATIN = 8'h00;
  localparam logic [7:0] ENC_UTF16 = 8'h01;
  localparam logic [7:0] ENC_UTF8  = 8'h03;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_W    = 8'h57;

  localparam logic [31:0] ID_TXXX = 32'h5458_5858;
  localparam logic [31:0] ID_WXXX = 32'h5758_5858;
  localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
  localparam logic [31:0] ID_USLT = 32'h5553_4C54;

  localparam logic [1:0] FLD_ENC   = 2'd0;
  localparam logic [1:0] FLD_LANG  = 2'd1;
  localparam logic [1:0] FLD_DESC  = 2'd2;
  localparam logic [1:0] FLD_VALUE = 2'd3;

  localparam logic [1:0] ENCC_LATIN = 2'd0;
  localparam logic [1:0] ENCC_UTF8  = 2'd1;
  localparam logic [1:0] ENCC_OTHER = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FHDR,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_HDR_OK,
    EV_BAD_ID,
    EV_BAD_VER,
    EV_CONTENT,
    EV_FIELD_END,
    EV_FRAME_END,
    EV_TAG_END
  } ev_t;

  typedef enum logic [2:0] {
    CL_TEXT,
    CL_TXXX,
    CL_URL,
    CL_WXXX,
    CL_COMM,
    CL_USLT,
    CL_NONE
  } cls_t;

  // A plain entry carries no frame context on the output side.
  typedef struct packed {
    logic       plain;
    ev_t        ev;
    logic [7:0] data;
    logic [1:0] fld;
  } entry_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] tag;
    logic [1:0]  enc;
  } ctx_t;

  typedef struct packed {
    logic [CNT_W-1:0]          n;
    entry_t [RES_MAX-1:0]      ent;
    ctx_t                      ctx;
  } batch_t;

  function automatic entry_t mk_ent(input logic plain, input ev_t ev,
                                    input logic [7:0] data, input logic [1:0] fld);
    entry_t e;
    e.plain = plain;
    e.ev    = ev;
    e.data  = data;
    e.fld   = fld;
    return e;
  endfunction

  function automatic cls_t classify(input logic [31:0] id);
    cls_t c;
    if (id == ID_TXXX) c = CL_TXXX;
    else if (id[31:24] == CHAR_T) c = CL_TEXT;
    else if (id == ID_WXXX) c = CL_WXXX;
    else if (id[31:24] == CHAR_W) c = CL_URL;
    else if (id == ID_COMM) c = CL_COMM;
    else if (id == ID_USLT) c = CL_USLT;
    else c = CL_NONE;
    return c;
  endfunction

  function automatic logic [1:0] enc_class(input logic [7:0] enc);
    logic [1:0] r;
    if (enc == ENC_LATIN) r = ENCC_LATIN;
    else if (enc == ENC_UTF8) r = ENCC_UTF8;
    else r = ENCC_OTHER;
    return r;
  endfunction

endpackage

[rtl/core/id3_res_q.sv]
module id3_res_q
  import id3_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  batch_t        batch,
  output logic          load_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    event_res,
  output logic [7:0]    out_byte,
  output logic [2:0]    frame_class,
  output logic [1:0]    field_index,
  output logic [31:0]   frame_tag,
  output logic [1:0]    encoding_class
);

  entry_t [RES_MAX-1:0] ent;
  ctx_t                 ctx;
  logic [CNT_W-1:0]     cnt;
  logic                 pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  // A new batch may land when the queue is empty or once the last pending result leaves in this cycle.
  assign load_ok   = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= batch.n;
    end else if (pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= batch.ent;
      ctx <= batch.ctx;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        ent[i] <= ent[i+1];
      end
    end
  end

  assign event_res      = ent[0].ev;
  assign out_byte       = ent[0].data;
  assign field_index    = ent[0].fld;
  assign frame_class    = ent[0].plain ? CL_NONE : ctx.cls;
  assign frame_tag      = ent[0].plain ? 32'd0 : ctx.tag;
  assign encoding_class = ent[0].plain ? ENCC_LATIN : ctx.enc;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(RES_MAX))
    else $error("result count beyond capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("result count not decremented on transfer");

  a_load_cnt: assert property (@(posedge clk) disable iff (rst)
    (load && batch.n != '0) |=> out_valid && cnt == $past(batch.n))
    else $error("loaded batch not presented");

endmodule

[rtl/core/id3v2_tag_frame_parser.sv]
// ID3v2.4 tag and frame parser.
// Input channel: one file byte per transfer (in_byte), with file_start set on
// the first byte of each file; file_start restarts the header check.
// Output channel: one event per transfer with its byte, frame class, field
// index, frame id and encoding class; a byte may cause zero to five events.
// Each accepted byte is decoded in the cycle it is accepted and its events
// are registered, so the first event appears in the cycle after the transfer.
// A byte causing at most one event sustains one byte per cycle while the
// receiver is ready; a byte causing more events holds the input while the
// result queue drains, as only one event leaves per cycle. The queue holds
// five events, the most that a single byte can cause.
// Reset empties the result queue and returns the parser to the tag header
// check. When the receiver stalls, pending events stay queued and in_ready
// stays low while any event is still waiting.
module id3v2_tag_frame_parser
  import id3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  out_byte,
  output logic [2:0]  frame_class,
  output logic [1:0]  field_index,
  output logic [31:0] frame_tag,
  output logic [1:0]  encoding_class
);

  phase_t            phase, phase_next, eff_phase;
  logic [3:0]        hcount, hcount_next, eff_count;
  logic [LEN_W-1:0]  tag_len, tag_len_next, len_shift;
  logic [LEN_W-1:0]  tag_left, tag_left_next;
  logic [31:0]       current_id, current_id_next;
  logic [LEN_W-1:0]  body_length, body_length_next, blen_shift;
  logic [LEN_W-1:0]  body_left, body_left_next;
  logic [1:0]        pos, pos_next;
  logic              body_short, body_short_next;
  cls_t              current_class, current_class_next;
  logic [7:0]        enc_value, enc_value_next;
  logic [1:0]        field_stage, field_stage_next;
  logic              zero_held, zero_held_next;
  logic              string_closed, string_closed_next;
  logic              lang;
  logic              take;
  logic [CNT_W-1:0]  n;
  batch_t            batch;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hcount        <= '0;
      tag_len       <= '0;
      tag_left      <= '0;
      current_id    <= '0;
      body_length   <= '0;
      body_left     <= '0;
      pos           <= '0;
      body_short    <= 1'b0;
      current_class <= CL_NONE;
      enc_value     <= '0;
      field_stage   <= '0;
      zero_held     <= 1'b0;
      string_closed <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      hcount        <= hcount_next;
      tag_len       <= tag_len_next;
      tag_left      <= tag_left_next;
      current_id    <= current_id_next;
      body_length   <= body_length_next;
      body_left     <= body_left_next;
      pos           <= pos_next;
      body_short    <= body_short_next;
      current_class <= current_class_next;
      enc_value     <= enc_value_next;
      field_stage   <= field_stage_next;
      zero_held     <= zero_held_next;
      string_closed <= string_closed_next;
    end
  end

  always_comb begin
    eff_phase = file_start ? PH_HEADER : phase;
    eff_count = file_start ? 4'd0 : hcount;
    len_shift  = {tag_len[LEN_W-8:0], in_byte[6:0] & SYNC_MASK};
    blen_shift = {body_length[LEN_W-8:0], in_byte[6:0] & SYNC_MASK};
    lang = (current_class == CL_COMM) || (current_class == CL_USLT);

    phase_next         = eff_phase;
    hcount_next        = eff_count;
    tag_len_next       = tag_len;
    tag_left_next      = tag_left;
    current_id_next    = current_id;
    body_length_next   = body_length;
    body_left_next     = body_left;
    pos_next           = pos;
    body_short_next    = body_short;
    current_class_next = current_class;
    enc_value_next     = enc_value;
    field_stage_next   = field_stage;
    zero_held_next     = zero_held;
    string_closed_next = string_closed;

    n = '0;
    batch.ent = '0;

    case (eff_phase)
      PH_HEADER: begin
        hcount_next = eff_count + 4'd1;
        if ((eff_count == 4'd0 && in_byte != BYTE_I) ||
            (eff_count == 4'd1 && in_byte != BYTE_D) ||
            (eff_count == 4'd2 && in_byte != BYTE_3)) begin
          batch.ent[n] = mk_ent(1'b1, EV_BAD_ID, 8'd0, FLD_ENC);
          n = n + CNT_W'(1);
          phase_next = PH_DONE;
        end else if ((eff_count == 4'd3 && in_byte != VER_MAJOR) ||
                     (eff_count == 4'd4 && in_byte != VER_MINOR)) begin
          batch.ent[n] = mk_ent(1'b1, EV_BAD_VER, 8'd0, FLD_ENC);
          n = n + CNT_W'(1);
          phase_next = PH_DONE;
        end else begin
          if (eff_count >= 4'd6) tag_len_next = len_shift;
          if (eff_count == 4'd9) begin
            batch.ent[n] = mk_ent(1'b1, EV_HDR_OK, 8'd0, FLD_ENC);
            n = n + CNT_W'(1);
            tag_left_next = len_shift;
            if (len_shift < HDR_LEN) begin
              batch.ent[n] = mk_ent(1'b1, EV_TAG_END, 8'd0, FLD_ENC);
              n = n + CNT_W'(1);
              phase_next = PH_DONE;
            end else begin
              phase_next  = PH_FHDR;
              hcount_next = 4'd0;
            end
          end
        end
      end

      PH_FHDR: begin
        hcount_next = eff_count + 4'd1;
        // The frame header itself is taken off the remaining tag bytes here.
        if (eff_count == 4'd0) begin
          current_id_next = {24'd0, in_byte};
          tag_left_next   = tag_left - HDR_LEN;
        end else if (eff_count < 4'd4) begin
          current_id_next = {current_id[23:0], in_byte};
        end else if (eff_count == 4'd4) begin
          body_length_next = {{(LEN_W-7){1'b0}}, in_byte[6:0] & SYNC_MASK};
        end else if (eff_count < 4'd8) begin
          body_length_next = blen_shift;
        end
        if (eff_count == 4'd9) begin
          if (body_length == '0 || body_length > tag_left) begin
            batch.ent[n] = mk_ent(1'b1, EV_TAG_END, 8'd0, FLD_ENC);
            n = n + CNT_W'(1);
            phase_next = PH_DONE;
          end else begin
            current_class_next = classify(current_id);
            field_stage_next   = (classify(current_id) == CL_URL) ? FLD_VALUE : FLD_ENC;
            enc_value_next     = 8'd0;
            zero_held_next     = 1'b0;
            string_closed_next = 1'b0;
            pos_next           = 2'd0;
            body_left_next     = body_length;
            body_short_next    = body_length < LANG_BODY;
            tag_left_next      = tag_left - body_length;
            phase_next         = PH_BODY;
          end
        end
      end

      PH_BODY: begin
        pos_next       = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
        body_left_next = body_left - LEN_W'(1);

        if (current_class == CL_NONE || string_closed) begin
          // silent byte
        end else if (current_class == CL_URL ||
                     (current_class == CL_WXXX && field_stage == FLD_VALUE)) begin
          // A url field has no terminator.
          batch.ent[n] = mk_ent(1'b0, EV_CONTENT, in_byte, field_stage);
          n = n + CNT_W'(1);
        end else if (pos == 2'd0) begin
          if (lang && body_short) begin
            string_closed_next = 1'b1;
          end else begin
            enc_value_next = in_byte;
            batch.ent[n] = mk_ent(1'b0, EV_CONTENT, in_byte, FLD_ENC);
            n = n + CNT_W'(1);
            batch.ent[n] = mk_ent(1'b0, EV_FIELD_END, 8'd0, FLD_ENC);
            n = n + CNT_W'(1);
            if (lang) field_stage_next = FLD_LANG;
            else if (current_class == CL_TEXT) field_stage_next = FLD_VALUE;
            else field_stage_next = FLD_DESC;
          end
        end else if (field_stage == FLD_LANG) begin
          batch.ent[n] = mk_ent(1'b0, EV_CONTENT, in_byte, FLD_LANG);
          n = n + CNT_W'(1);
          if (pos == 2'd3) begin
            batch.ent[n] = mk_ent(1'b0, EV_FIELD_END, 8'd0, FLD_LANG);
            n = n + CNT_W'(1);
            field_stage_next = FLD_DESC;
          end
        end else if (enc_value == ENC_UTF16 && zero_held) begin
          zero_held_next = 1'b0;
          if (in_byte == 8'd0) begin
            batch.ent[n] = mk_ent(1'b0, EV_FIELD_END, 8'd0, field_stage);
            n = n + CNT_W'(1);
            if (field_stage == FLD_DESC) field_stage_next = FLD_VALUE;
            else string_closed_next = 1'b1;
          end else begin
            batch.ent[n] = mk_ent(1'b0, EV_CONTENT, 8'd0, field_stage);
            n = n + CNT_W'(1);
            batch.ent[n] = mk_ent(1'b0, EV_CONTENT, in_byte, field_stage);
            n = n + CNT_W'(1);
          end
        end else if (enc_value == ENC_UTF16 && in_byte == 8'd0) begin
          zero_held_next = 1'b1;
        end else if (in_byte == 8'd0) begin
          batch.ent[n] = mk_ent(1'b0, EV_FIELD_END, 8'd0, field_stage);
          n = n + CNT_W'(1);
          if (field_stage == FLD_DESC) field_stage_next = FLD_VALUE;
          else string_closed_next = 1'b1;
        end else begin
          batch.ent[n] = mk_ent(1'b0, EV_CONTENT, in_byte, field_stage);
          n = n + CNT_W'(1);
        end

        if (body_left == LEN_W'(1)) begin
          if (current_class != CL_NONE) begin
            if (zero_held_next) begin
              batch.ent[n] = mk_ent(1'b0, EV_CONTENT, 8'd0, field_stage_next);
              n = n + CNT_W'(1);
              zero_held_next = 1'b0;
            end
            if (!string_closed_next) begin
              batch.ent[n] = mk_ent(1'b0, EV_FIELD_END, 8'd0, field_stage_next);
              n = n + CNT_W'(1);
            end
            batch.ent[n] = mk_ent(1'b0, EV_FRAME_END, 8'd0, field_stage_next);
            n = n + CNT_W'(1);
          end
          // tag_left already excludes this body.
          if (tag_left < HDR_LEN) begin
            batch.ent[n] = mk_ent(1'b1, EV_TAG_END, 8'd0, FLD_ENC);
            n = n + CNT_W'(1);
            phase_next = PH_DONE;
          end else begin
            phase_next  = PH_FHDR;
            hcount_next = 4'd0;
          end
        end
      end

      default: begin
      end
    endcase

    batch.n       = n;
    batch.ctx.cls = current_class;
    batch.ctx.tag = current_id;
    batch.ctx.enc = enc_class(enc_value_next);
  end

  id3_res_q u_res_q (
    .clk            (clk),
    .rst            (rst),
    .load           (take),
    .batch          (batch),
    .load_ok        (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .out_byte       (out_byte),
    .frame_class    (frame_class),
    .field_index    (field_index),
    .frame_tag      (frame_tag),
    .encoding_class (encoding_class)
  );

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (take && !file_start && phase == PH_DONE) |=> phase == PH_DONE)
    else $error("parser left the finished state without a new file");

  a_body_entry: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_BODY) |=> (phase != PH_BODY || $past(phase) == PH_FHDR))
    else $error("frame body entered other than from a frame header");

  a_body_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> body_left != '0)
    else $error("frame body active with no bytes left");

endmodule

[tb/id3v2_tag_frame_parser_tb.sv]
module id3v2_tag_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import id3_pkg::*;

  localparam int TARGET_BYTES = 360;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_PRINTS   = 100;

  typedef struct {
    logic [7:0] b;
    logic       start;
    logic       hold;
  } file_byte_t;

  typedef struct {
    ev_t         ev;
    logic [7:0]  data;
    cls_t        cls;
    logic [1:0]  fld;
    logic [31:0] tag;
    logic [1:0]  enc;
  } tag_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        file_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  out_byte;
  logic [2:0]  frame_class;
  logic [1:0]  field_index;
  logic [31:0] frame_tag;
  logic [1:0]  encoding_class;

  file_byte_t byte_feed[$];
  tag_event_t pending_events[$];
  logic [7:0] tag_body[$];
  logic [7:0] frame_body[$];

  // Totals move by nonblocking assignment so that the hold-off test in the
  // driver sees the same values whatever order the clocked blocks run in.
  int pred_total = 0;
  int seen_total = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int files_made = 0;
  int holds_made = 0;
  int ev_count[0:7];
  int new_events;
  int gap_left = 0;
  int stall_left = 0;
  logic in_paced = 1'b1;
  logic out_paced = 1'b1;

  // Parser state as predicted.
  phase_t      p_phase;
  logic [3:0]  p_hdr_cnt;
  logic [27:0] p_tag_len;
  logic [27:0] p_tag_pos;
  logic [31:0] p_id;
  logic [27:0] p_body_len;
  logic [27:0] p_body_pos;
  cls_t        p_cls;
  logic [7:0]  p_enc;
  logic [1:0]  p_stage;
  logic        p_zero_held;
  logic        p_closed;

  id3v2_tag_frame_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .file_start     (file_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .out_byte       (out_byte),
    .frame_class    (frame_class),
    .field_index    (field_index),
    .frame_tag      (frame_tag),
    .encoding_class (encoding_class)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- parser
  task automatic clear_parser();
    p_phase     = PH_HEADER;
    p_hdr_cnt   = '0;
    p_tag_len   = '0;
    p_tag_pos   = '0;
    p_id        = '0;
    p_body_len  = '0;
    p_body_pos  = '0;
    p_cls       = CL_NONE;
    p_enc       = '0;
    p_stage     = FLD_ENC;
    p_zero_held = 1'b0;
    p_closed    = 1'b0;
  endtask

  task automatic add_event(input ev_t ev, input logic [7:0] data, input cls_t cls,
                           input logic [1:0] fld, input logic [31:0] tag,
                           input logic [1:0] enc);
    tag_event_t e;
    e.ev   = ev;
    e.data = data;
    e.cls  = cls;
    e.fld  = fld;
    e.tag  = tag;
    e.enc  = enc;
    if (new_events < RES_MAX) begin
      pending_events = {pending_events, e};
      new_events++;
    end
  endtask

  task automatic add_plain(input ev_t ev);
    add_event(ev, 8'h00, CL_NONE, 2'd0, 32'h0, 2'd0);
  endtask

  task automatic add_frame_event(input ev_t ev, input logic [7:0] data,
                                 input logic [1:0] fld);
    logic [1:0] ec;
    if (p_enc == ENC_LATIN) ec = ENCC_LATIN;
    else if (p_enc == ENC_UTF8) ec = ENCC_UTF8;
    else ec = ENCC_OTHER;
    add_event(ev, data, p_cls, fld, p_id, ec);
  endtask

  function automatic cls_t frame_kind(input logic [31:0] id);
    if (id == ID_TXXX) return CL_TXXX;
    if (id[31:24] == CHAR_T) return CL_TEXT;
    if (id == ID_WXXX) return CL_WXXX;
    if (id[31:24] == CHAR_W) return CL_URL;
    if (id == ID_COMM) return CL_COMM;
    if (id == ID_USLT) return CL_USLT;
    return CL_NONE;
  endfunction

  // The tag ends here if a further frame header cannot fit.
  task automatic open_frame_header();
    logic [27:0] left;
    left = (p_tag_pos <= p_tag_len) ? p_tag_len - p_tag_pos : '0;
    if (left < HDR_LEN) begin
      add_plain(EV_TAG_END);
      p_phase = PH_DONE;
    end else begin
      p_phase   = PH_FHDR;
      p_hdr_cnt = '0;
    end
  endtask

  task automatic tag_header_byte(input logic [7:0] b);
    logic [3:0] k;
    k = p_hdr_cnt;
    if ((k == 0 && b != BYTE_I) || (k == 1 && b != BYTE_D) || (k == 2 && b != BYTE_3)) begin
      add_plain(EV_BAD_ID);
      p_phase = PH_DONE;
    end else if ((k == 3 && b != VER_MAJOR) || (k == 4 && b != VER_MINOR)) begin
      add_plain(EV_BAD_VER);
      p_phase = PH_DONE;
    end else begin
      if (k == 0) p_tag_len = '0;
      if (k >= 6) p_tag_len = {p_tag_len[20:0], b[6:0]};
      p_hdr_cnt = k + 4'd1;
      if (k == 9) begin
        add_plain(EV_HDR_OK);
        p_tag_pos = '0;
        open_frame_header();
      end
    end
  endtask

  task automatic frame_header_byte(input logic [7:0] b);
    logic [3:0] k;
    k = p_hdr_cnt;
    if (k == 0) p_id = {24'h0, b};
    else if (k < 4) p_id = {p_id[23:0], b};
    else if (k == 4) p_body_len = {21'h0, b[6:0]};
    else if (k < 8) p_body_len = {p_body_len[20:0], b[6:0]};
    p_hdr_cnt = k + 4'd1;
    if (k == 9) begin
      p_tag_pos = p_tag_pos + HDR_LEN;
      if (p_body_len == 0 || p_body_len > p_tag_len - p_tag_pos) begin
        add_plain(EV_TAG_END);
        p_phase = PH_DONE;
      end else begin
        p_cls       = frame_kind(p_id);
        p_body_pos  = '0;
        p_enc       = '0;
        p_stage     = (p_cls == CL_URL) ? FLD_VALUE : FLD_ENC;
        p_zero_held = 1'b0;
        p_closed    = 1'b0;
        p_phase     = PH_BODY;
      end
    end
  endtask

  // A terminator ends the description and moves on to the value, or else
  // closes the frame's last string.
  task automatic close_field();
    add_frame_event(EV_FIELD_END, 8'h00, p_stage);
    if (p_stage == FLD_DESC) p_stage = FLD_VALUE;
    else p_closed = 1'b1;
  endtask

  task automatic body_byte(input logic [7:0] b);
    cls_t        c;
    logic [27:0] pos;
    logic        lang;
    c    = p_cls;
    pos  = p_body_pos;
    lang = (c == CL_COMM) || (c == CL_USLT);
    if (c != CL_NONE && !p_closed) begin
      if (c == CL_URL || (c == CL_WXXX && p_stage == FLD_VALUE)) begin
        add_frame_event(EV_CONTENT, b, p_stage);
      end else if (pos == 0) begin
        if (lang && p_body_len < LANG_BODY) begin
          p_closed = 1'b1;
        end else begin
          p_enc = b;
          add_frame_event(EV_CONTENT, b, FLD_ENC);
          add_frame_event(EV_FIELD_END, 8'h00, FLD_ENC);
          p_stage = lang ? FLD_LANG : ((c == CL_TEXT) ? FLD_VALUE : FLD_DESC);
        end
      end else if (p_stage == FLD_LANG) begin
        add_frame_event(EV_CONTENT, b, FLD_LANG);
        if (pos >= 3) begin
          add_frame_event(EV_FIELD_END, 8'h00, FLD_LANG);
          p_stage = FLD_DESC;
        end
      end else if (p_enc == ENC_UTF16) begin
        if (p_zero_held) begin
          p_zero_held = 1'b0;
          if (b == 8'h00) begin
            close_field();
          end else begin
            add_frame_event(EV_CONTENT, 8'h00, p_stage);
            add_frame_event(EV_CONTENT, b, p_stage);
          end
        end else if (b == 8'h00) begin
          p_zero_held = 1'b1;
        end else begin
          add_frame_event(EV_CONTENT, b, p_stage);
        end
      end else if (b == 8'h00) begin
        close_field();
      end else begin
        add_frame_event(EV_CONTENT, b, p_stage);
      end
    end
    p_body_pos = pos + 28'd1;
    if (({4'd0, pos} + 32'd1) >= {4'd0, p_body_len}) begin
      if (c != CL_NONE) begin
        if (p_zero_held) begin
          add_frame_event(EV_CONTENT, 8'h00, p_stage);
          p_zero_held = 1'b0;
        end
        if (!p_closed) add_frame_event(EV_FIELD_END, 8'h00, p_stage);
        add_frame_event(EV_FRAME_END, 8'h00, p_stage);
      end
      p_tag_pos = p_tag_pos + p_body_len;
      open_frame_header();
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic start);
    new_events = 0;
    if (start) clear_parser();
    case (p_phase)
      PH_HEADER: tag_header_byte(b);
      PH_FHDR:   frame_header_byte(b);
      PH_BODY:   body_byte(b);
      default:   ;
    endcase
  endtask

  // ------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b, input logic start, input logic hold);
    file_byte_t fb;
    fb.b     = b;
    fb.start = start;
    fb.hold  = hold;
    byte_feed = {byte_feed, fb};
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  // Synchsafe size byte i (0 = most significant); bit 7 is random and must
  // be ignored by the block.
  function automatic logic [7:0] sync_byte(input logic [27:0] sz, input int i);
    return {1'($urandom_range(0, 1)), 7'(sz >> (7 * (3 - i)))};
  endfunction

  task automatic add_random_frame();
    logic [31:0] id;
    logic [27:0] sz;
    logic [7:0]  e;
    int          kind;
    int          n;
    int          r;
    int          keep;
    int          i;
    frame_body.delete();
    kind = $urandom_range(0, 7);
    case (kind)
      0: id = {CHAR_T, rand_letter(), rand_letter(), rand_letter()};
      1: id = ID_TXXX;
      2: id = {CHAR_W, rand_letter(), rand_letter(), rand_letter()};
      3: id = ID_WXXX;
      4: id = ID_COMM;
      5: id = ID_USLT;
      default: begin
        id = $urandom;
        if (id[31:24] == CHAR_T || id[31:24] == CHAR_W) id[31:24] = 8'h00;
      end
    endcase
    if (kind == 2 || kind > 5) begin
      n = $urandom_range(1, 12);
      repeat (n)
        frame_body = {frame_body, (($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom))};
    end else begin
      r = $urandom_range(0, 5);
      if (r == 0) e = ENC_LATIN;
      else if (r <= 2) e = ENC_UTF16;
      else if (r == 3) e = ENC_UTF8;
      else e = 8'($urandom);
      frame_body = {frame_body, e};
      if (kind >= 4) repeat (3) frame_body = {frame_body, 8'($urandom)};
      n = $urandom_range(0, 12);
      repeat (n) begin
        r = $urandom_range(0, 7);
        if (r < 2) begin
          frame_body = {frame_body, 8'h00};
        end else if (r == 2) begin
          frame_body = {frame_body, 8'h00};
          frame_body = {frame_body, 8'h00};
        end else begin
          frame_body = {frame_body, 8'($urandom_range(1, 255))};
        end
      end
    end
    keep = frame_body.size();
    if (kind >= 4 && kind <= 5 && $urandom_range(0, 3) == 0) keep = $urandom_range(1, 3);
    else if ($urandom_range(0, 5) == 0) keep = $urandom_range(1, keep);
    while (frame_body.size() > keep) frame_body.delete(frame_body.size() - 1);
    sz = 28'(frame_body.size());
    r = $urandom_range(0, 15);
    if (r == 0) sz = '0;
    else if (r == 1) sz = sz + 28'($urandom_range(1, 40));
    else if (r == 2) sz = 28'h0FFFFFFF;
    for (i = 0; i < 4; i++) tag_body = {tag_body, 8'(id >> (8 * (3 - i)))};
    for (i = 0; i < 4; i++) tag_body = {tag_body, sync_byte(sz, i)};
    tag_body = {tag_body, 8'($urandom)};
    tag_body = {tag_body, 8'($urandom)};
    foreach (frame_body[j]) tag_body = {tag_body, frame_body[j]};
  endtask

  task automatic add_random_file(input logic hold);
    logic [7:0]  hdr[10];
    logic [27:0] tsz;
    logic        first_start;
    int          nfr;
    int          pad;
    int          total;
    int          i;
    int          r;
    tag_body.delete();
    nfr = $urandom_range(0, 3);
    repeat (nfr) add_random_frame();
    pad = $urandom_range(0, 12);
    repeat (pad)
      tag_body = {tag_body, (($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00)};
    tsz = 28'(tag_body.size());
    r = $urandom_range(0, 9);
    if (r == 0) tsz = 28'($urandom_range(0, tag_body.size()));
    else if (r == 1) tsz = 28'h0FFFFFFF;
    hdr[0] = BYTE_I;
    hdr[1] = BYTE_D;
    hdr[2] = BYTE_3;
    hdr[3] = VER_MAJOR;
    hdr[4] = VER_MINOR;
    hdr[5] = 8'($urandom);
    for (i = 0; i < 4; i++) hdr[6 + i] = sync_byte(tsz, i);
    r = $urandom_range(0, 11);
    if (r == 0) begin
      i = $urandom_range(0, 2);
      hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
    end else if (r == 1) begin
      i = $urandom_range(3, 4);
      hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
    end
    total = 10 + tag_body.size();
    // Now and then the file is cut short by the start of the next one.
    if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
    first_start = ($urandom_range(0, 14) != 0);
    for (i = 0; i < total; i++) begin
      if (i < 10) push_byte(hdr[i], (i == 0) ? first_start : 1'b0, (i == 0) ? hold : 1'b0);
      else push_byte(tag_body[i - 10], 1'b0, 1'b0);
    end
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0, 1'b0);
    files_made++;
    if (hold) holds_made++;
  endtask

  task automatic add_directed_bytes();
    // No start flag after reset, and a wrong third identifier byte.
    push_byte(BYTE_I, 1'b0, 1'b0);
    push_byte(BYTE_D, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // Wrong major version.
    push_byte(BYTE_I, 1'b1, 1'b0);
    push_byte(BYTE_D, 1'b0, 1'b0);
    push_byte(BYTE_3, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0);
    // Tag of 18 bytes holding a 3-byte comment; the tag then ends as no
    // second frame header fits. The tag size bytes carry bit 7 set.
    push_byte(BYTE_I, 1'b1, 1'b0);
    push_byte(BYTE_D, 1'b0, 1'b0);
    push_byte(BYTE_3, 1'b0, 1'b0);
    push_byte(VER_MAJOR, 1'b0, 1'b0);
    push_byte(VER_MINOR, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h92, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(8'(ID_COMM >> (8 * (3 - i))), 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(ENC_UTF16, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------- driver
  always @(posedge clk) begin
    logic       nv;
    logic       load;
    int         pt;
    file_byte_t fb;
    if (rst) begin
      in_valid   <= 1'b0;
      in_byte    <= 8'h00;
      file_start <= 1'b0;
      gap_left    = 0;
    end else begin
      nv   = in_valid;
      load = 1'b0;
      pt   = pred_total;
      if (in_valid && in_ready) begin
        predict_byte(in_byte, file_start);
        pt = pred_total + new_events;
        bytes_sent++;
        nv = 1'b0;
        gap_left = in_paced ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 39) == 0) in_paced = !in_paced;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_feed.size() > 0 && (!byte_feed[0].hold || pt == seen_total)) begin
          fb   = byte_feed.pop_front();
          load = 1'b1;
          nv   = 1'b1;
        end
      end
      if (load) begin
        in_byte    <= fb.b;
        file_start <= fb.start;
      end else if (!nv) begin
        in_byte    <= 8'($urandom);
        file_start <= 1'($urandom);
      end
      in_valid   <= nv;
      pred_total <= pt;
    end
  end

  // -------------------------------------------------------------- monitor
  always @(posedge clk) begin
    logic       nr;
    tag_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      nr = out_ready;
      if (out_valid && out_ready) begin
        ev_count[event_res]++;
        if (pending_events.size() == 0) begin
          report_mismatch("event with none expected", {29'h0, event_res}, 32'h0);
        end else begin
          want = pending_events.pop_front();
          seen_total <= seen_total + 1;
          if (event_res !== want.ev)
            report_mismatch("event_res", 32'(event_res), 32'(want.ev));
          if (out_byte !== want.data)
            report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
          if (frame_class !== want.cls)
            report_mismatch("frame_class", 32'(frame_class), 32'(want.cls));
          if (field_index !== want.fld)
            report_mismatch("field_index", 32'(field_index), 32'(want.fld));
          if (frame_tag !== want.tag)
            report_mismatch("frame_tag", frame_tag, want.tag);
          if (encoding_class !== want.enc)
            report_mismatch("encoding_class", 32'(encoding_class), 32'(want.enc));
        end
        stall_left = out_paced ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 39) == 0) out_paced = !out_paced;
        nr = (stall_left == 0);
      end else if (!out_ready) begin
        if (stall_left > 0) stall_left--;
        nr = (stall_left == 0);
      end
      out_ready <= nr;
    end
  end

  // ------------------------------------------------------------- sequence
  initial begin
    foreach (ev_count[i]) ev_count[i] = 0;
    clear_parser();
    add_directed_bytes();
    // The first random file waits until every earlier event has drained.
    add_random_file(1'b1);
    while (byte_feed.size() < TARGET_BYTES)
      add_random_file($urandom_range(0, 9) == 0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Sampled away from the rising edge so that every update has settled.
    while (byte_feed.size() != 0 || in_valid || pred_total != seen_total) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch("events never produced", pending_events.size(), 32'h0);
    $display("Fed %0d bytes from %0d files (%0d held until drained), checked %0d events.",
             bytes_sent, files_made + 3, holds_made, seen_total);
    $display({"Events: %0d header ok, %0d bad id, %0d bad version, %0d content, ",
              "%0d field end, %0d frame end, %0d tag end."},
             ev_count[0], ev_count[1], ev_count[2], ev_count[3], ev_count[4],
             ev_count[5], ev_count[6]);
    if (mismatches == 0) begin
      $display("PASS id3v2_tag_frame_parser");
    end else begin
      $display("FAIL id3v2_tag_frame_parser");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("Run did not complete in time.");
    $display("FAIL id3v2_tag_frame_parser");
    $finish;
  end

endmodule
